>>> src/oaid_pkg.sv
// Shared types and codes for the ordered array insert/delete block.
package oaid_pkg;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_DEL_KEY = 2'd1,
    K_DEL_POS = 2'd2,
    K_READ    = 2'd3
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WALK,
    S_DRAIN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic walk_done;
  } dp_stat_t;

endpackage

>>> src/oaid_ctrl.sv
// Controller state machine: sequences load, check, walk, drain and commit.
module oaid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  oaid_pkg::dp_stat_t stat,
  output oaid_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  oaid_pkg::state_t state_r;
  oaid_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oaid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oaid_pkg::S_IDLE: begin
        if (start) state_nxt = oaid_pkg::S_EVAL;
      end
      oaid_pkg::S_EVAL: begin
        state_nxt = stat.err ? oaid_pkg::S_FIN : oaid_pkg::S_WALK;
      end
      oaid_pkg::S_WALK: begin
        if (stat.walk_done) state_nxt = oaid_pkg::S_DRAIN;
      end
      oaid_pkg::S_DRAIN: begin
        state_nxt = oaid_pkg::S_FIN;
      end
      oaid_pkg::S_FIN: begin
        state_nxt = oaid_pkg::S_IDLE;
      end
      default: begin
        state_nxt = oaid_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      oaid_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      oaid_pkg::S_EVAL:  cmd.setup  = 1'b1;
      oaid_pkg::S_WALK:  cmd.step   = !stat.walk_done;
      oaid_pkg::S_DRAIN: cmd.step   = 1'b0;
      oaid_pkg::S_FIN:   cmd.finish = 1'b1;
      default:           cmd        = '0;
    endcase
  end

endmodule

>>> src/oaid_dp.sv
// Datapath: entry memory, walk pointers, range checks and result registers.
module oaid_dp #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  oaid_pkg::dp_cmd_t        cmd,
  input  logic [1:0]               in_kind,
  input  logic signed [31:0]       in_value,
  input  logic [6:0]               in_position,
  output oaid_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [6:0]               out_entry_count,
  output logic signed [31:0]       out_read_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic signed [31:0] mem [DEPTH];

  oaid_pkg::kind_t    kind_r;
  logic signed [31:0] val_r;
  logic [6:0]         pos_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      src_r;
  logic [CW-1:0]      left_r;
  logic [CW-1:0]      w_r;
  logic [AW-1:0]      sa_r;
  logic               pv_r;
  logic signed [31:0] rdata_r;
  logic signed [31:0] rd_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [6:0]         out_count_r;
  logic signed [31:0] out_rd_r;

  logic [1:0]         code;
  logic [PW-1:0]      pos_x;
  logic [PW-1:0]      cnt_x;
  logic [CW-1:0]      pos_c;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  assign pos_x = PW'(pos_r);
  assign cnt_x = PW'(count_r);
  assign pos_c = CW'(pos_r);

  always_comb begin
    code = oaid_pkg::ST_OK;
    unique case (kind_r) inside
      oaid_pkg::K_INSERT: begin
        if (count_r == CW'(DEPTH)) code = oaid_pkg::ST_FULL;
        else if (pos_x > cnt_x)    code = oaid_pkg::ST_RANGE;
      end
      oaid_pkg::K_DEL_KEY: code = oaid_pkg::ST_OK;
      oaid_pkg::K_DEL_POS, oaid_pkg::K_READ: begin
        if (pos_x >= cnt_x) code = oaid_pkg::ST_RANGE;
      end
    endcase
  end

  assign stat.err       = (code != oaid_pkg::ST_OK);
  assign stat.walk_done = (left_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (code == oaid_pkg::ST_OK) begin
      unique case (kind_r)
        oaid_pkg::K_INSERT:  count_nxt = count_r + CW'(1);
        oaid_pkg::K_DEL_KEY: count_nxt = w_r;
        oaid_pkg::K_DEL_POS: count_nxt = count_r - CW'(1);
        oaid_pkg::K_READ:    count_nxt = count_r;
      endcase
    end
  end

  // Write port: shifted or kept words while draining the walk, new word at commit.
  always_comb begin
    we    = 1'b0;
    waddr = sa_r;
    wdata = rdata_r;
    if (cmd.finish) begin
      we    = (kind_r == oaid_pkg::K_INSERT) && (code == oaid_pkg::ST_OK);
      waddr = AW'(pos_r);
      wdata = val_r;
    end else if (pv_r) begin
      unique case (kind_r)
        oaid_pkg::K_INSERT: begin
          we    = 1'b1;
          waddr = sa_r + AW'(1);
        end
        oaid_pkg::K_DEL_KEY: begin
          we    = (rdata_r != val_r);
          waddr = w_r[AW-1:0];
        end
        oaid_pkg::K_DEL_POS: begin
          we    = 1'b1;
          waddr = sa_r - AW'(1);
        end
        oaid_pkg::K_READ: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[src_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      left_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pv_r        <= cmd.step;
      out_valid_r <= cmd.finish;
      if (cmd.setup) begin
        unique case (kind_r)
          oaid_pkg::K_INSERT: begin
            src_r  <= count_r - CW'(1);
            left_r <= count_r - pos_c;
          end
          oaid_pkg::K_DEL_KEY: begin
            src_r  <= '0;
            left_r <= count_r;
          end
          oaid_pkg::K_DEL_POS: begin
            src_r  <= pos_c + CW'(1);
            left_r <= count_r - pos_c - CW'(1);
          end
          oaid_pkg::K_READ: begin
            src_r  <= pos_c;
            left_r <= CW'(1);
          end
        endcase
      end else if (cmd.step) begin
        src_r  <= (kind_r == oaid_pkg::K_INSERT) ? src_r - CW'(1) : src_r + CW'(1);
        left_r <= left_r - CW'(1);
      end
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= oaid_pkg::kind_t'(in_kind);
      val_r  <= in_value;
      pos_r  <= in_position;
    end
    if (cmd.setup) begin
      w_r  <= '0;
      rd_r <= '0;
    end else if (pv_r) begin
      if ((kind_r == oaid_pkg::K_DEL_KEY) && (rdata_r != val_r)) w_r <= w_r + CW'(1);
      if (kind_r == oaid_pkg::K_READ) rd_r <= rdata_r;
    end
    if (cmd.step) begin
      sa_r <= src_r[AW-1:0];
    end
    if (cmd.finish) begin
      out_status_r <= code;
      out_count_r  <= 7'(count_nxt);
      out_rd_r     <= ((code == oaid_pkg::ST_OK) && (kind_r == oaid_pkg::K_READ)) ? rd_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_read_value  = out_rd_r;

endmodule

>>> src/ordered_array_insert_delete_top.sv
// Top level of the ordered array store: controller plus datapath.
//
//   channel  direction  ports                                   handshake
//   input    in         in_kind, in_value, in_position          start & !busy
//   result   out        out_status, out_entry_count,            out_valid, one cycle
//                       out_read_value
//
// An accepted item keeps busy high through its walk of n entries, where n is:
// count - position for insert, count - position - 1 for delete at position, count for
// delete by key, one for a read. An item that fails its check skips the walk.
// The walk moves one entry per cycle; the entry memory reads one word and writes one word
// a cycle, with registered read data. The result word shows in the first cycle busy is low.
// Synchronous rst_n clears state, count, walk and out_valid; the receiver cannot stall the result word.
module ordered_array_insert_delete_top #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic [6:0]         in_position,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_entry_count,
  output logic signed [31:0] out_read_value
);

  // Commands from the controller, status back from the datapath.
  oaid_pkg::dp_cmd_t  cmd;
  oaid_pkg::dp_stat_t stat;

  // Sequence: accept, check and set up the walk, step one entry per cycle,
  // drain the last read, then commit count and emit the result word.
  oaid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the entries, the count and the walk pointers; shift or compact in place.
  oaid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_position     (in_position),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_value  (out_read_value)
  );

endmodule

>>> src/oaid_checker.sv
// Port-level checks for the ordered array store, bound to the top level.
module oaid_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_read_value
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted word");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("no result word when busy fell");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy ##1 !out_valid)
    else $error("result strobe longer than one cycle or while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == oaid_pkg::ST_OK) || (out_status == oaid_pkg::ST_FULL) ||
                   (out_status == oaid_pkg::ST_RANGE)))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != oaid_pkg::ST_OK)) |-> (out_read_value == 32'sd0))
    else $error("read value not zero on error");

endmodule

bind ordered_array_insert_delete_top oaid_checker u_oaid_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_read_value (out_read_value)
);

>>> bench/ordered_array_insert_delete_top_test.sv
// Self-checking testbench for the ordered array insert/delete block.
`timescale 1ns / 1ps

module ordered_array_insert_delete_top_test;

  localparam int DEPTH       = 64;
  localparam int STALL_LIMIT = 2000;  // longest walk plus longest sender gap, many times over
  localparam int DRAIN_WAIT  = 80;    // covers a full-depth walk after the last result
  localparam int RAND_ITEMS  = 1200;

  // One expected result word, as the block should present it.
  typedef struct {
    logic [1:0]         status;
    logic [6:0]         entry_count;
    logic signed [31:0] read_value;
  } reply_t;

  // Mirror of the stored list plus the queue of replies still owed by the block.
  class ordered_list_model;
    logic signed [31:0] slots [DEPTH];
    int unsigned        fill;
    reply_t             owed [$];
    int unsigned        errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Apply one accepted word to the mirror and queue the reply it must produce.
    function void note_request(oaid_pkg::kind_t kind, logic signed [31:0] value,
                               logic [6:0] position);
      reply_t      rep;
      int unsigned keep;
      rep.status     = oaid_pkg::ST_OK;
      rep.read_value = '0;
      case (kind)
        oaid_pkg::K_INSERT: begin
          // Full check wins over the position check.
          if (fill >= DEPTH) begin
            rep.status = oaid_pkg::ST_FULL;
          end else if (position > fill) begin
            rep.status = oaid_pkg::ST_RANGE;
          end else begin
            for (int i = fill; i > position; i--) slots[i] = slots[i-1];
            slots[position] = value;
            fill++;
          end
        end
        oaid_pkg::K_DEL_KEY: begin
          // Compact in place; position plays no part.
          keep = 0;
          for (int i = 0; i < fill; i++) begin
            if (slots[i] !== value) begin
              slots[keep] = slots[i];
              keep++;
            end
          end
          fill = keep;
        end
        oaid_pkg::K_DEL_POS: begin
          if (position >= fill) begin
            rep.status = oaid_pkg::ST_RANGE;
          end else begin
            for (int i = position; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        default: begin
          if (position >= fill) rep.status = oaid_pkg::ST_RANGE;
          else rep.read_value = slots[position];
        end
      endcase
      rep.entry_count = fill[6:0];
      owed.push_back(rep);
    endfunction

    // Compare one result word against the oldest owed reply.
    function void check_reply(logic [1:0] status, logic [6:0] entry_count,
                              logic signed [31:0] read_value);
      reply_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word: status %0d count %0d value %0d",
                 $time, status, entry_count, read_value);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, status);
        errors++;
      end
      if (entry_count !== want.entry_count) begin
        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                 $time, want.entry_count, entry_count);
        errors++;
      end
      if (read_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                 $time, want.read_value, read_value);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_kind;
  logic signed [31:0] in_value;
  logic [6:0]         in_position;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [6:0]         out_entry_count;
  logic signed [31:0] out_read_value;

  ordered_list_model list_model = new();
  int unsigned       stall_cycles;

  // Keys reused often so that delete-by-key finds duplicates.
  logic signed [31:0] key_pool [8] = '{32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1,
                                      32'sd5, 32'sd17, -32'sd300, 32'sh12345678};

  ordered_array_insert_delete_top #(.DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_value  (out_read_value)
  );

  // 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Present one word and hold it until the block takes it, then log it in the model.
  // Return at the edge that accepted the word, with start still high.
  task automatic send_word(oaid_pkg::kind_t kind, logic signed [31:0] value,
                           logic [6:0] position);
    in_kind     <= kind;
    in_value    <= value;
    in_position <= position;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    list_model.note_request(kind, value, position);
  endtask

  // Drop start for a random stretch; short gaps mostly, now and then one that spans a full walk.
  task automatic maybe_idle(bit allow);
    int unsigned span;
    if (allow && $urandom_range(99) < 30) begin
      span = ($urandom_range(9) == 0) ? $urandom_range(7, 80) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (span) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(1) == 0) return key_pool[3'($urandom_range(7))];
    return $urandom();
  endfunction

  // Position: mostly legal for the kind at the current fill, sometimes anywhere in 0..127.
  function automatic logic [6:0] pick_position(oaid_pkg::kind_t kind);
    int unsigned fill;
    fill = list_model.fill;
    if ($urandom_range(9) == 0) return 7'($urandom_range(127));
    if (kind == oaid_pkg::K_INSERT) return 7'($urandom_range(fill));
    if (fill == 0) return 7'($urandom_range(3));
    return 7'($urandom_range(fill - 1));
  endfunction

  // Filling phases lean on insert, draining phases on the two deletes.
  function automatic oaid_pkg::kind_t pick_kind(bit filling);
    int unsigned roll;
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 60) return oaid_pkg::K_INSERT;
      if (roll < 80) return oaid_pkg::K_READ;
      if (roll < 90) return oaid_pkg::K_DEL_POS;
      return oaid_pkg::K_DEL_KEY;
    end
    if (roll < 15) return oaid_pkg::K_INSERT;
    if (roll < 35) return oaid_pkg::K_READ;
    if (roll < 80) return oaid_pkg::K_DEL_POS;
    return oaid_pkg::K_DEL_KEY;
  endfunction

  // Check every result word on the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      list_model.check_reply(out_status, out_entry_count, out_read_value);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    oaid_pkg::kind_t    kind;
    logic signed [31:0] value;
    logic [6:0]         position;
    bit                 filling;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_kind     <= oaid_pkg::K_READ;
    in_value    <= '0;
    in_position <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list errors and a no-match key delete first.
    send_word(oaid_pkg::K_READ,    32'sd0, 7'd0);
    send_word(oaid_pkg::K_DEL_POS, 32'sd0, 7'd0);
    send_word(oaid_pkg::K_INSERT,  32'sd9, 7'd1);     // insert past count
    send_word(oaid_pkg::K_DEL_KEY, 32'sd5, 7'd0);     // no match on empty list
    // Build a short list with extreme words, front, middle and append inserts.
    send_word(oaid_pkg::K_INSERT,  32'sh7fffffff, 7'd0);
    send_word(oaid_pkg::K_INSERT,  32'sh80000000, 7'd1);
    send_word(oaid_pkg::K_INSERT,  -32'sd1, 7'd0);
    send_word(oaid_pkg::K_INSERT,  32'sd0, 7'd1);
    send_word(oaid_pkg::K_INSERT,  32'sd5, 7'd4);     // append at position equal to count
    send_word(oaid_pkg::K_INSERT,  32'sd5, 7'd2);
    send_word(oaid_pkg::K_INSERT,  32'sd1, 7'd127);   // far out of range
    send_word(oaid_pkg::K_READ,    32'sd0, 7'd0);
    send_word(oaid_pkg::K_READ,    32'sd0, 7'd5);
    send_word(oaid_pkg::K_READ,    32'sd0, 7'd6);     // read at count
    send_word(oaid_pkg::K_READ,    32'sd0, 7'd127);
    // Delete-by-key with duplicates; position must be ignored.
    send_word(oaid_pkg::K_DEL_KEY, 32'sd5, 7'd127);
    send_word(oaid_pkg::K_DEL_KEY, 32'sd1234, 7'd0);
    send_word(oaid_pkg::K_READ,    32'sd0, 7'd2);
    send_word(oaid_pkg::K_DEL_POS, 32'sd0, 7'd3);     // last entry
    send_word(oaid_pkg::K_DEL_POS, 32'sd0, 7'd0);     // first entry
    send_word(oaid_pkg::K_DEL_POS, 32'sd0, 7'd64);
    send_word(oaid_pkg::K_INSERT,  32'sd7, 7'd64);
    send_word(oaid_pkg::K_READ,    32'sd0, 7'd1);

    // Random: alternate fill and drain phases so the list hits full and empty repeatedly.
    filling = 1'b1;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (filling && list_model.fill == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      else if (!filling && (list_model.fill == 0 || $urandom_range(199) == 0)) filling = 1'b1;
      kind     = pick_kind(filling);
      value    = pick_value();
      position = pick_position(kind);
      // Hold start continuously through the middle stretch.
      maybe_idle(!(n >= 400 && n < 600));
      send_word(kind, value, position);
    end
    start <= 1'b0;

    // Drain: wait for owed replies, then watch a while longer for stray words.
    while (list_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (list_model.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
